// File: design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// File: design/pt4_pkg.sv
`default_nettype none
package pt4_pkg;

  // Geometry of the table store and of one table frame.
  localparam int unsigned TABLE_FRAMES_DEF = 64;
  localparam int unsigned ENTRIES = 512;
  localparam int unsigned IDX_W = 9;

  // Request codes.
  localparam logic [1:0] REQ_MAP = 2'd0;
  localparam logic [1:0] REQ_UNMAP = 2'd1;
  localparam logic [1:0] REQ_XLATE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_UNALIGNED = 2'd1;
  localparam logic [1:0] ST_NO_FRAMES = 2'd2;
  localparam logic [1:0] ST_NOT_MAPPED = 2'd3;

  // Entry flag bits.
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_WRITABLE = 1;
  localparam int unsigned BIT_USER = 2;

  // Table index of a virtual address at a level, level 0 being the root.
  function automatic logic [IDX_W-1:0] lvl_idx(input logic [63:0] va, input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0: idx = va[47:39];
      2'd1: idx = va[38:30];
      2'd2: idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage
`default_nettype wire

// File: design/pt4_store.sv
`default_nettype none
module pt4_store #(
  parameter int unsigned AW = 15
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [63:0]   wdata_i,
  output logic      [63:0]   rdata_o
);

  // Single-port table store with a registered read.
  logic [63:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule
`default_nettype wire

// File: design/four_level_page_table_manager.sv
`default_nettype none
// Four-level page table manager with a local store of table frames.
// Requests enter on start when busy is low, with req_type_i (map, unmap,
// translate), virt_addr_i, phys_addr_i and leaf_flags_i. Each item gives
// exactly one result, shown for one cycle with done_o: status_o,
// phys_out_o and invalidate_o. The receiver cannot stall, so results are
// never held back; busy stays high until the cycle of the done_o strobe.
// Every table access goes through the single port of the table store, one
// entry per cycle, so that port sets the pace of each item: a map also
// zeroes every table that it newly creates, and an unmap scans the tables
// along its walk for emptiness, leaf table first (up to three).
// The APB port holds table_region_base at address 0 (64-bit data).
// After reset a clearing pass empties the root table and fills the free
// frame stack; busy is high meanwhile, while register writes are taken as
// usual.
module four_level_page_table_manager #(
  parameter int unsigned TABLE_FRAMES = pt4_pkg::TABLE_FRAMES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [63:0] virt_addr_i,
  input  wire logic [63:0] phys_addr_i,
  input  wire logic [63:0] leaf_flags_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [63:0]      phys_out_o,
  output logic             invalidate_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);
  import pt4_pkg::*;

  localparam int unsigned FW = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
  localparam int unsigned AW = FW + IDX_W;
  localparam int unsigned INIT_LEN = (TABLE_FRAMES > ENTRIES) ? TABLE_FRAMES : ENTRIES;
  localparam int unsigned CW = $clog2(INIT_LEN + 1);
  localparam logic [FW-1:0] MAX_FREE = FW'(TABLE_FRAMES - 1);

  typedef enum logic [9:0] {
    S_INIT = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_RD   = 10'b0000000100,
    S_CHK  = 10'b0000001000,
    S_POP  = 10'b0000010000,
    S_ZERO = 10'b0000100000,
    S_LINK = 10'b0001000000,
    S_SCAN = 10'b0010000000,
    S_FREE = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [1:0] lvl_q, lvl_d;
  logic [FW-1:0] cur_q, cur_d;
  logic [FW-1:0] fr_q [4];
  logic fr_we;
  logic [FW-1:0] fr_wdata;
  logic [1:0] req_q;
  logic [63:0] va_q, pa_q, lf_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic chk_q, chk_d;
  logic [FW-1:0] nf_q, nf_d;
  logic [FW-1:0] fcnt_q, fcnt_d;
  logic [39:0] base_q;
  logic [1:0] status_q, status_d;
  logic [63:0] phys_q, phys_d;
  logic inval_q, inval_d;
  logic done_q, done_d;

  // Table store port.
  logic st_en, st_we;
  logic [AW-1:0] st_addr;
  logic [63:0] st_wdata, st_rdata;

  // Free frame stack.
  logic [FW-1:0] stk_mem [TABLE_FRAMES];
  logic stk_we, stk_re;
  logic [FW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata_q;

  // Shared walk unit: pointer check of the entry just read.
  logic [39:0] off;
  logic hit;
  logic [FW-1:0] hit_frame;
  logic [IDX_W-1:0] cur_idx;
  logic [63:0] int_flags;
  logic [39:0] new_addr;
  logic [1:0] par_lvl;

  assign off = st_rdata[51:12] - base_q;
  assign hit = st_rdata[BIT_PRESENT] && (off < 40'(TABLE_FRAMES));
  assign hit_frame = off[FW-1:0];
  assign cur_idx = lvl_idx(va_q, lvl_q);
  assign par_lvl = lvl_q - 2'd1;
  assign int_flags = {61'd0, lf_q[BIT_USER], 2'b11};
  assign new_addr = base_q + 40'(nf_q);

  pt4_store #(.AW(AW)) u_store (
    .clk_i   (clk_i),
    .en_i    (st_en),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i (st_wdata),
    .rdata_o (st_rdata)
  );

  // Sequencer.
  always_comb begin
    state_d = state_q;
    lvl_d = lvl_q;
    cur_d = cur_q;
    cnt_d = cnt_q;
    chk_d = 1'b0;
    nf_d = nf_q;
    fcnt_d = fcnt_q;
    status_d = status_q;
    phys_d = phys_q;
    inval_d = inval_q;
    done_d = 1'b0;
    fr_we = 1'b0;
    fr_wdata = hit_frame;
    st_en = 1'b0;
    st_we = 1'b0;
    st_addr = {cur_q, cur_idx};
    st_wdata = '0;
    stk_we = 1'b0;
    stk_waddr = fcnt_q;
    stk_wdata = cur_q;
    stk_re = 1'b0;
    stk_raddr = fcnt_q - FW'(1);
    case (state_q)
      S_INIT: begin
        if (cnt_q < CW'(ENTRIES)) begin
          st_en = 1'b1;
          st_we = 1'b1;
          st_addr = {{FW{1'b0}}, cnt_q[IDX_W-1:0]};
        end
        if (cnt_q < CW'(TABLE_FRAMES - 1)) begin
          stk_we = 1'b1;
          stk_waddr = cnt_q[FW-1:0];
          stk_wdata = MAX_FREE - cnt_q[FW-1:0];
        end
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(INIT_LEN - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          lvl_d = 2'd0;
          cur_d = '0;
          status_d = ST_OK;
          phys_d = '0;
          inval_d = 1'b0;
          if (req_type_i == REQ_UNMAP && virt_addr_i[11:0] != 12'd0) begin
            status_d = ST_UNALIGNED;
            state_d = S_DONE;
          end else if (req_type_i == REQ_MAP || req_type_i == REQ_UNMAP ||
                       req_type_i == REQ_XLATE) begin
            state_d = S_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_RD: begin
        st_en = 1'b1;
        if (req_q == REQ_MAP && lvl_q == 2'd3) begin
          st_we = 1'b1;
          st_wdata = {12'd0, pa_q[51:12], 12'd0} | lf_q | 64'd1;
          st_wdata[63:52] = pa_q[63:52] | lf_q[63:52];
          inval_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (lvl_q != 2'd3) begin
          if (hit) begin
            fr_we = 1'b1;
            cur_d = hit_frame;
            lvl_d = lvl_q + 2'd1;
            state_d = S_RD;
          end else if (req_q == REQ_MAP) begin
            if (fcnt_q == '0) begin
              status_d = ST_NO_FRAMES;
              state_d = S_DONE;
            end else begin
              stk_re = 1'b1;
              fcnt_d = fcnt_q - FW'(1);
              state_d = S_POP;
            end
          end else begin
            if (req_q == REQ_XLATE) begin
              status_d = ST_NOT_MAPPED;
              phys_d = '1;
            end
            state_d = S_DONE;
          end
        end else if (req_q == REQ_XLATE) begin
          if (st_rdata[BIT_PRESENT]) begin
            phys_d = {12'd0, st_rdata[51:12], va_q[11:0]};
          end else begin
            status_d = ST_NOT_MAPPED;
            phys_d = '1;
          end
          state_d = S_DONE;
        end else if (st_rdata[BIT_PRESENT]) begin
          // Clear the leaf, then check its table for emptiness.
          st_en = 1'b1;
          st_we = 1'b1;
          inval_d = 1'b1;
          cnt_d = '0;
          state_d = S_SCAN;
        end else begin
          state_d = S_DONE;
        end
      end
      S_POP: begin
        nf_d = stk_rdata_q;
        cnt_d = '0;
        state_d = S_ZERO;
      end
      S_ZERO: begin
        st_en = 1'b1;
        st_we = 1'b1;
        st_addr = {nf_q, cnt_q[IDX_W-1:0]};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(ENTRIES - 1)) begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        st_en = 1'b1;
        st_we = 1'b1;
        st_wdata = {12'd0, new_addr, 12'd0} | int_flags;
        fr_we = 1'b1;
        fr_wdata = nf_q;
        cur_d = nf_q;
        lvl_d = lvl_q + 2'd1;
        state_d = S_RD;
      end
      S_SCAN: begin
        // One read per cycle; the entry read last cycle is checked now.
        if (cnt_q < CW'(ENTRIES)) begin
          st_en = 1'b1;
          st_addr = {cur_q, cnt_q[IDX_W-1:0]};
          chk_d = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
        if (chk_q && st_rdata != '0) begin
          state_d = S_DONE;
        end else if (cnt_q == CW'(ENTRIES)) begin
          state_d = S_FREE;
        end
      end
      S_FREE: begin
        st_en = 1'b1;
        st_we = 1'b1;
        st_addr = {fr_q[par_lvl], lvl_idx(va_q, par_lvl)};
        if (cur_q != '0 && fcnt_q < MAX_FREE) begin
          stk_we = 1'b1;
          fcnt_d = fcnt_q + FW'(1);
        end
        cur_d = fr_q[par_lvl];
        lvl_d = par_lvl;
        cnt_d = '0;
        state_d = (par_lvl == 2'd0) ? S_DONE : S_SCAN;
      end
      S_DONE: begin
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      lvl_q <= '0;
      cur_q <= '0;
      cnt_q <= '0;
      chk_q <= 1'b0;
      fcnt_q <= MAX_FREE;
      done_q <= 1'b0;
      base_q <= '0;
    end else begin
      state_q <= state_d;
      lvl_q <= lvl_d;
      cur_q <= cur_d;
      cnt_q <= cnt_d;
      chk_q <= chk_d;
      fcnt_q <= fcnt_d;
      done_q <= done_d;
      if (psel && penable && pwrite && !paddr[3]) begin
        base_q <= pwdata[51:12];
      end
    end
  end

  // Payload registers; the root table always sits in frame zero.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      req_q <= req_type_i;
      va_q <= virt_addr_i;
      pa_q <= phys_addr_i;
      lf_q <= leaf_flags_i;
    end
    fr_q[0] <= '0;
    if (fr_we) begin
      fr_q[lvl_q + 2'd1] <= fr_wdata;
    end
    nf_q <= nf_d;
    status_q <= status_d;
    phys_q <= phys_d;
    inval_q <= inval_d;
  end

  // Free stack memory.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
  end

  assign busy = (state_q != S_IDLE);
  assign done_o = done_q;
  assign status_o = status_q;
  assign phys_out_o = phys_q;
  assign invalidate_o = inval_q;
  assign prdata = paddr[3] ? 64'd0 : {12'd0, base_q, 12'd0};
  assign pready = 1'b1;

endmodule
`default_nettype wire

// File: design/pt4_checker.sv
`default_nettype none
`include "assert_macros.svh"
module pt4_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic [63:0] phys_out_o,
  input wire logic        invalidate_o
);
  import pt4_pkg::*;

  // An accepted item keeps the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // A result only closes a period of work.
  `ASSERT_SAME(a_done_after_busy, done_o, $past(busy))
  // A translation miss always reports the all-ones address.
  `ASSERT_SAME(a_miss_ones, done_o && status_o == ST_NOT_MAPPED, phys_out_o == '1)
  // Invalidation only comes with a successful result.
  `ASSERT_SAME(a_inval_ok, done_o && invalidate_o, status_o == ST_OK)

endmodule

bind four_level_page_table_manager pt4_checker u_pt4_checker (.*);
`default_nettype wire

// File: tb/sv/tb_four_level_page_table_manager.sv
`timescale 1ns / 100ps
module tb_four_level_page_table_manager;
  import pt4_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [63:0] ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam int NFRAMES = TABLE_FRAMES_DEF;
  localparam int NENT = ENTRIES;

  typedef struct packed {
    logic [1:0]  req;
    logic [63:0] va;
    logic [63:0] pa;
    logic [63:0] flags;
  } pt_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] phys;
    logic        inval;
  } pt_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [63:0] virt_addr_i = '0;
  logic [63:0] phys_addr_i = '0;
  logic [63:0] leaf_flags_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [63:0] phys_out_o;
  logic        invalidate_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  four_level_page_table_manager dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_type_i(req_type_i), .virt_addr_i(virt_addr_i), .phys_addr_i(phys_addr_i),
    .leaf_flags_i(leaf_flags_i), .done_o(done_o), .status_o(status_o),
    .phys_out_o(phys_out_o), .invalidate_o(invalidate_o), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the table store, free frame stack and base register.
  logic [63:0] shadow_tables [0:NFRAMES*NENT-1];
  int          free_stack [0:NFRAMES-1];
  int          free_cnt;
  logic [63:0] region_base;

  pt_item_t   item_q [$];
  pt_result_t xlat_q [$];
  pt_item_t   cur_item;
  bit         hold_sender = 1'b0;
  int         accepted = 0;
  int         errors = 0;
  int         n_map = 0, n_unmap = 0, n_xlate = 0, n_other = 0;
  int         n_oof = 0, n_hit = 0, n_miss = 0, n_inval = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [63:0] frame_addr(input int f);
    return (region_base + (64'(f) << 12)) & ADDR_MASK;
  endfunction

  // Frame that a present entry points to; entries outside the store miss.
  function automatic bit entry_frame(input logic [63:0] e, output int f);
    logic [63:0] off;
    f = 0;
    if (!e[BIT_PRESENT]) return 1'b0;
    off = (((e & ADDR_MASK) - region_base) & ADDR_MASK) >> 12;
    if (off >= 64'(NFRAMES)) return 1'b0;
    f = int'(off);
    return 1'b1;
  endfunction

  // One level of the walk: 0 found or created, 1 absent, 2 out of frames.
  function automatic int walk_level(input int cur, input int idx, input bit alloc,
                                    input logic [63:0] fl, output int nxt);
    int slot;
    int f;
    slot = cur * NENT + idx;
    nxt = 0;
    if (entry_frame(shadow_tables[slot], f)) begin
      nxt = f;
      return 0;
    end
    if (!alloc) return 1;
    if (free_cnt == 0) return 2;
    free_cnt--;
    f = free_stack[free_cnt];
    for (int i = 0; i < NENT; i++) shadow_tables[f*NENT+i] = '0;
    shadow_tables[slot] = frame_addr(f) | fl;
    nxt = f;
    return 0;
  endfunction

  function automatic bit frame_empty(input int f);
    for (int i = 0; i < NENT; i++)
      if (shadow_tables[f*NENT+i] != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void release_frame(input int f);
    if (f == 0 || f >= NFRAMES || free_cnt >= NFRAMES - 1) return;
    free_stack[free_cnt] = f;
    free_cnt++;
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < NFRAMES*NENT; i++) shadow_tables[i] = '0;
    for (int i = 0; i < NFRAMES; i++) free_stack[i] = 0;
    for (int i = 0; i < NFRAMES - 1; i++) free_stack[i] = NFRAMES - 1 - i;
    free_cnt = NFRAMES - 1;
    region_base = '0;
  endfunction

  // Applies one request to the shadow tables and returns the expected result.
  function automatic pt_result_t walk_request(input pt_item_t it);
    pt_result_t r;
    int i4, i3, i2, i1, f3, f2, f1;
    logic [63:0] af, e;
    bit hit;
    i4 = int'(it.va[47:39]);
    i3 = int'(it.va[38:30]);
    i2 = int'(it.va[29:21]);
    i1 = int'(it.va[20:12]);
    r = '{status: ST_OK, phys: '0, inval: 1'b0};
    case (it.req)
      REQ_MAP: begin
        n_map++;
        af = 64'h3 | (it.flags & 64'h4);
        if (walk_level(0, i4, 1'b1, af, f3) != 0 || walk_level(f3, i3, 1'b1, af, f2) != 0 ||
            walk_level(f2, i2, 1'b1, af, f1) != 0) begin
          r.status = ST_NO_FRAMES;
          n_oof++;
        end else begin
          shadow_tables[f1*NENT+i1] = (it.pa & ~64'hFFF) | it.flags | 64'h1;
          r.inval = 1'b1;
        end
      end
      REQ_UNMAP: begin
        n_unmap++;
        if (it.va[11:0] != 0) begin
          r.status = ST_UNALIGNED;
        end else if (walk_level(0, i4, 1'b0, '0, f3) == 0 &&
                     walk_level(f3, i3, 1'b0, '0, f2) == 0 &&
                     walk_level(f2, i2, 1'b0, '0, f1) == 0 &&
                     shadow_tables[f1*NENT+i1][BIT_PRESENT]) begin
          shadow_tables[f1*NENT+i1] = '0;
          r.inval = 1'b1;
          if (frame_empty(f1)) begin
            shadow_tables[f2*NENT+i2] = '0;
            release_frame(f1);
            if (frame_empty(f2)) begin
              shadow_tables[f3*NENT+i3] = '0;
              release_frame(f2);
              if (frame_empty(f3)) begin
                shadow_tables[i4] = '0;
                release_frame(f3);
              end
            end
          end
        end
      end
      REQ_XLATE: begin
        n_xlate++;
        e = '0;
        hit = walk_level(0, i4, 1'b0, '0, f3) == 0 && walk_level(f3, i3, 1'b0, '0, f2) == 0 &&
              walk_level(f2, i2, 1'b0, '0, f1) == 0;
        if (hit) begin
          e = shadow_tables[f1*NENT+i1];
          hit = e[BIT_PRESENT];
        end
        if (hit) begin
          r.phys = (e & ADDR_MASK) + {52'h0, it.va[11:0]};
          n_hit++;
        end else begin
          r.status = ST_NOT_MAPPED;
          r.phys = '1;
          n_miss++;
        end
      end
      default: n_other++;
    endcase
    if (r.inval) n_inval++;
    return r;
  endfunction

  // Driver: presents queued items, idling at random outside one long stretch.
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    bit taken;
    bit idle;
    pt_item_t nx;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        xlat_q.push_back(walk_request(cur_item));
        accepted++;
      end
      idle = ($urandom_range(99) < 27) && !(accepted >= 120 && accepted < 220);
      if (start && !taken) begin
        // Keep the item on the ports until it is taken.
      end else if (item_q.size() > 0 && !hold_sender && !idle) begin
        nx = item_q.pop_front();
        cur_item = nx;
        start <= 1'b1;
        req_type_i <= nx.req;
        virt_addr_i <= nx.va;
        phys_addr_i <= nx.pa;
        leaf_flags_i <= nx.flags;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    pt_result_t x;
    if (rst_ni && done_o) begin
      if (xlat_q.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        x = xlat_q.pop_front();
        if (status_o !== x.status)
          report_mismatch($sformatf("status %0d, expected %0d", status_o, x.status));
        if (phys_out_o !== x.phys)
          report_mismatch($sformatf("phys_out %h, expected %h", phys_out_o, x.phys));
        if (invalidate_o !== x.inval)
          report_mismatch($sformatf("invalidate %b, expected %b", invalidate_o, x.inval));
      end
    end
  end

  function automatic pt_item_t mk(input logic [1:0] rq, input logic [63:0] va,
                                  input logic [63:0] pa, input logic [63:0] fl);
    pt_item_t it;
    it.req = rq;
    it.va = va;
    it.pa = pa;
    it.flags = fl;
    return it;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] make_va(input int i4, input int i3, input int i2,
                                          input int i1, input logic [11:0] off);
    return {16'($urandom()), 9'(i4), 9'(i3), 9'(i2), 9'(i1), off};
  endfunction

  task automatic wait_idle();
    do @(posedge clk_i);
    while (item_q.size() != 0 || start || xlat_q.size() != 0 || busy);
  endtask

  task automatic write_base(input logic [63:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    region_base = v & ADDR_MASK;
  endtask

  // Queues an unmap for every complete mapping held in the shadow tables.
  task automatic queue_teardown();
    int f3, f2, f1;
    for (int a = 0; a < NENT; a++)
      if (entry_frame(shadow_tables[a], f3))
        for (int b = 0; b < NENT; b++)
          if (entry_frame(shadow_tables[f3*NENT+b], f2))
            for (int c = 0; c < NENT; c++)
              if (entry_frame(shadow_tables[f2*NENT+c], f1))
                for (int d = 0; d < NENT; d++)
                  if (shadow_tables[f1*NENT+d][BIT_PRESENT])
                    item_q.push_back(mk(REQ_UNMAP, make_va(a, b, c, d, 12'h0), rnd64(), rnd64()));
  endtask

  // Random traffic over a small pool of table indices, plus some noise.
  task automatic queue_random(input int count);
    int p4 [2];
    int p3 [2];
    int p2 [4];
    int p1 [4];
    int sel;
    logic [63:0] va;
    foreach (p4[i]) p4[i] = $urandom_range(511);
    foreach (p3[i]) p3[i] = $urandom_range(511);
    foreach (p2[i]) p2[i] = $urandom_range(511);
    foreach (p1[i]) p1[i] = $urandom_range(511);
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      va = make_va(p4[$urandom_range(1)], p3[$urandom_range(1)], p2[$urandom_range(3)],
                   p1[$urandom_range(3)], 12'($urandom()));
      if (sel < 40)
        item_q.push_back(mk(REQ_MAP, va, rnd64(), rnd64()));
      else if (sel < 65)
        item_q.push_back(mk(REQ_UNMAP, {va[63:12], 12'h0}, rnd64(), rnd64()));
      else if (sel < 90)
        item_q.push_back(mk(REQ_XLATE, va, rnd64(), rnd64()));
      else if (sel < 93)
        item_q.push_back(mk(REQ_XLATE, rnd64(), rnd64(), rnd64()));
      else if (sel < 96)
        item_q.push_back(mk(REQ_UNMAP, rnd64(), rnd64(), rnd64()));
      else
        item_q.push_back(mk(REQ_UNKNOWN, rnd64(), rnd64(), rnd64()));
    end
  endtask

  initial begin : stimulus
    logic [63:0] va;
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_base(64'h0);

    // Directed: empty-table cases, unknown code, extremes of the fields.
    item_q.push_back(mk(REQ_XLATE, 64'h0, '0, '0));
    item_q.push_back(mk(REQ_UNMAP, 64'h0, '0, '0));
    item_q.push_back(mk(REQ_UNMAP, 64'h123, '0, '0));
    item_q.push_back(mk(REQ_UNKNOWN, '1, '1, '1));
    item_q.push_back(mk(REQ_MAP, '1, '1, 64'h0));
    item_q.push_back(mk(REQ_XLATE, '1, '0, '0));
    item_q.push_back(mk(REQ_MAP, 64'h0, 64'h0, '1));
    item_q.push_back(mk(REQ_XLATE, 64'hFFF, '0, '0));
    item_q.push_back(mk(REQ_MAP, 64'h0, 64'h0000_0ABC_DEF0_1FFF, 64'h4));
    item_q.push_back(mk(REQ_XLATE, 64'h7FF, '0, '0));
    item_q.push_back(mk(REQ_UNMAP, 64'hFFFF_FFFF_FFFF_F000, '0, '0));
    item_q.push_back(mk(REQ_XLATE, '1, '0, '0));
    item_q.push_back(mk(REQ_UNMAP, 64'h0, '0, '0));
    item_q.push_back(mk(REQ_XLATE, 64'h0, '0, '0));
    wait_idle();

    // Drain fully, then exhaust the frame stack with one root slot per map.
    hold_sender = 1'b1;
    wait_idle();
    hold_sender = 1'b0;
    for (int k = 1; k <= 22; k++)
      item_q.push_back(mk(REQ_MAP, make_va(k, 0, 0, 0, 12'h0), rnd64(), 64'h0));
    wait_idle();
    queue_teardown();
    wait_idle();

    // Random phases, each under a new table base with an empty root.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: write_base(64'h000F_FFFF_FFFF_FFFF);
        1: write_base({12'h0, 52'(rnd64())});
        default: write_base(64'h0);
      endcase
      queue_random(80);
      wait_idle();
      queue_teardown();
      wait_idle();
    end

    // Entries that fall outside the store after a base change count as absent.
    va = make_va(5, 6, 7, 8, 12'h0);
    item_q.push_back(mk(REQ_MAP, va, 64'h1234_5000, 64'h0));
    wait_idle();
    write_base(64'h0 - 64'h100000);
    item_q.push_back(mk(REQ_XLATE, va | 64'h55, '0, '0));
    item_q.push_back(mk(REQ_MAP, va, 64'h6789_A000, 64'h4));
    item_q.push_back(mk(REQ_XLATE, va | 64'hAA, '0, '0));
    wait_idle();

    repeat (50) @(posedge clk_i);
    $display("Covered %0d items: %0d map, %0d unmap, %0d translate, %0d unknown.",
             accepted, n_map, n_unmap, n_xlate, n_other);
    $display("Seen %0d hits, %0d misses, %0d out-of-frame maps, %0d invalidates.",
             n_hit, n_miss, n_oof, n_inval);
    if (errors == 0) begin
      $display("four_level_page_table_manager test passed");
    end else begin
      $display("four_level_page_table_manager test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("four_level_page_table_manager test failed");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/pt4_pkg.sv
design/pt4_store.sv
design/four_level_page_table_manager.sv
design/pt4_checker.sv
tb/sv/tb_four_level_page_table_manager.sv
